// ----- src/allt_pkg.sv -----
// Shared types, constants and breakpoint tables for the ambient light level tracker.
// No dependencies.
package allt_pkg;

  localparam int LEVEL_MAX   = 100;
  localparam int LUX_W       = 20;
  localparam int EXP_W       = 20;
  localparam int GAIN_W      = 16;
  localparam int TICK_W      = 32;
  localparam int LEVEL_W     = 8;
  localparam int CFG_W       = 20;
  localparam int X_W         = LUX_W + GAIN_W;   // lux * gain, 2^-16 lux units
  localparam int SEG_W       = 3;                // eight segments
  localparam int NSEG        = 8;
  localparam int OFF_W       = 21;               // offset into a segment, < 30 * 2^16
  localparam int PROD_W      = LEVEL_W + OFF_W;
  localparam int Q_W         = PROD_W - 16;
  localparam int RECIP_W     = 18;
  localparam int RECIP_SHIFT = 20;

  localparam logic [EXP_W-1:0]  EXP_RESET  = EXP_W'(4000);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);

  // register indexes
  localparam logic CFG_EXPOSURE = 1'b0;
  localparam logic CFG_GAIN     = 1'b1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FAIL   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SEG,
    S_PROD,
    S_QUOT,
    S_FIN
  } allt_state_t;

  typedef struct packed {
    logic upd;    // take the input word, update held value and window
    logic mul;    // x = held lux * gain
    logic seg;    // locate segment, form offset
    logic prod;   // slope product
    logic quot;   // divide by segment width, add base level
    logic load;   // load the output register
  } allt_cmd_t;

  // upper breakpoint of segment i, whole lux
  function automatic logic [6:0] seg_x1(input logic [SEG_W-1:0] i);
    logic [6:0] r;
    unique case (i)
      3'd0: r = 7'd5;
      3'd1: r = 7'd10;
      3'd2: r = 7'd15;
      3'd3: r = 7'd20;
      3'd4: r = 7'd30;
      3'd5: r = 7'd50;
      3'd6: r = 7'd70;
      default: r = 7'd100;
    endcase
    return r;
  endfunction

  // lower breakpoint of segment i, whole lux
  function automatic logic [6:0] seg_x0(input logic [SEG_W-1:0] i);
    logic [6:0] r;
    unique case (i)
      3'd0: r = 7'd0;
      3'd1: r = 7'd5;
      3'd2: r = 7'd10;
      3'd3: r = 7'd15;
      3'd4: r = 7'd20;
      3'd5: r = 7'd30;
      3'd6: r = 7'd50;
      default: r = 7'd70;
    endcase
    return r;
  endfunction

  function automatic logic [LEVEL_W-1:0] seg_y0(input logic [SEG_W-1:0] i);
    logic [LEVEL_W-1:0] r;
    unique case (i)
      3'd0: r = 8'd0;
      3'd1: r = 8'd10;
      3'd2: r = 8'd24;
      3'd3: r = 8'd34;
      3'd4: r = 8'd50;
      3'd5: r = 8'd61;
      3'd6: r = 8'd77;
      default: r = 8'd89;
    endcase
    return r;
  endfunction

  function automatic logic [LEVEL_W-1:0] seg_dy(input logic [SEG_W-1:0] i);
    logic [LEVEL_W-1:0] r;
    unique case (i)
      3'd0: r = 8'd10;
      3'd1: r = 8'd14;
      3'd2: r = 8'd10;
      3'd3: r = 8'd16;
      3'd4: r = 8'd11;
      3'd5: r = 8'd16;
      3'd6: r = 8'd12;
      default: r = LEVEL_W'(LEVEL_MAX - 89);
    endcase
    return r;
  endfunction

  // ceil(2^20 / width) for segment widths 5, 10, 20, 30; exact for q < 2^13
  function automatic logic [RECIP_W-1:0] seg_recip(input logic [SEG_W-1:0] i);
    logic [RECIP_W-1:0] r;
    unique case (i) inside
      [3'd0:3'd3]: r = 18'd209716;
      3'd4:        r = 18'd104858;
      3'd5, 3'd6:  r = 18'd52429;
      default:     r = 18'd34953;
    endcase
    return r;
  endfunction

endpackage

// ----- src/ambient_light_level_tracker.sv -----
// Ambient light level tracker, top level: controller plus datapath.
// A new input word is accepted only after the previous word has been loaded
// into the output register, so words pass one at a time through the multiply/segment/
// slope/divide sequence in the datapath; longer if the output word is not taken.
// Reset (rst, synchronous): held lux unknown, window cleared, exposure 4000 ms,
// gain 1.0, no result pending.
module ambient_light_level_tracker (
  input  logic                          clk,
  input  logic                          rst,
  // config write port
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [allt_pkg::CFG_W-1:0]    cfg_data,
  // input words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [allt_pkg::LUX_W-1:0]    lux,
  input  logic [allt_pkg::TICK_W-1:0]   now_ms,
  // result words
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [allt_pkg::LEVEL_W-1:0]  level,
  output logic                          lux_known,
  output logic [allt_pkg::LUX_W-1:0]    held_lux
);
  import allt_pkg::*;

  allt_cmd_t cmd;

  // The controller steps one word through: accept/update, multiply, segment
  // search, slope product, reciprocal divide, then output load. The output
  // register lets a new word enter while the previous result waits.
  allt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Held lux and window state are updated on the accepting edge; the level
  // pipeline then works on the updated state, which stays stable until the
  // next word is accepted.
  allt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op        (op),
    .lux       (lux),
    .now_ms    (now_ms),
    .level     (level),
    .lux_known (lux_known),
    .held_lux  (held_lux)
  );

endmodule

// ----- src/allt_ctrl.sv -----
// Sequencing state machine for the ambient light level tracker.
// Depends on allt_pkg.
module allt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output allt_pkg::allt_cmd_t cmd
);
  import allt_pkg::*;

  allt_state_t state, state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.upd    = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SEG;
      end
      S_SEG: begin
        cmd.seg    = 1'b1;
        state_next = S_PROD;
      end
      S_PROD: begin
        cmd.prod   = 1'b1;
        state_next = S_QUOT;
      end
      S_QUOT: begin
        cmd.quot   = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// ----- src/allt_dp.sv -----
// Datapath: config registers, held lux / window state, gain multiply and interpolation.
// Depends on allt_pkg.
module allt_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  allt_pkg::allt_cmd_t           cmd,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [allt_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          op,
  input  logic [allt_pkg::LUX_W-1:0]    lux,
  input  logic [allt_pkg::TICK_W-1:0]   now_ms,
  output logic [allt_pkg::LEVEL_W-1:0]  level,
  output logic                          lux_known,
  output logic [allt_pkg::LUX_W-1:0]    held_lux
);
  import allt_pkg::*;

  logic [EXP_W-1:0]   exposure_ticks;
  logic [GAIN_W-1:0]  gain_coef;
  logic [LUX_W-1:0]   current_lux;
  logic               current_valid;
  logic [LUX_W-1:0]   window_peak;
  logic [TICK_W-1:0]  window_start;

  logic [X_W-1:0]     x;
  logic [SEG_W-1:0]   seg;
  logic               sat;
  logic [OFF_W-1:0]   off;
  logic [Q_W-1:0]     q;
  logic [LEVEL_W-1:0] lvl;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      exposure_ticks <= EXP_RESET;
      gain_coef      <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPOSURE: exposure_ticks <= cfg_data[EXP_W-1:0];
        CFG_GAIN:     gain_coef      <= cfg_data[GAIN_W-1:0];
        default:      ;
      endcase
    end
  end

  // held value and window update
  logic [LUX_W-1:0]  peak_max;
  logic [TICK_W-1:0] age;

  assign peak_max = (window_peak < lux) ? lux : window_peak;
  assign age      = now_ms - window_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_lux   <= '0;
      current_valid <= 1'b0;
      window_peak   <= '0;
      window_start  <= '0;
    end else if (cmd.upd) begin
      if (op == OP_FAIL) begin
        current_valid <= 1'b0;
      end else if (!current_valid || current_lux < lux) begin
        current_lux   <= lux;
        current_valid <= 1'b1;
        window_peak   <= '0;
        window_start  <= now_ms;
      end else if (age >= TICK_W'(exposure_ticks)) begin
        current_lux   <= peak_max;
        current_valid <= 1'b1;
        window_peak   <= '0;
        window_start  <= now_ms;
      end else begin
        window_peak <= peak_max;
      end
    end
  end

  // segment search: count breakpoints at or below x
  logic [SEG_W:0]   nbelow;
  logic [LUX_W-1:0] x_hi;
  logic [6:0]       x0;

  assign x_hi = x[X_W-1:16];
  assign x0   = seg_x0(nbelow[SEG_W-1:0]);

  always_comb begin
    nbelow = '0;
    for (int i = 0; i < NSEG; i++) begin
      if (x_hi >= LUX_W'(seg_x1(SEG_W'(i)))) begin
        nbelow = nbelow + 1'b1;
      end
    end
  end

  logic [PROD_W-1:0]              slope_prod;
  logic [Q_W+RECIP_W-1:0]         quot_prod;

  assign slope_prod = PROD_W'(seg_dy(seg)) * PROD_W'(off);
  assign quot_prod  = (Q_W + RECIP_W)'(q) * (Q_W + RECIP_W)'(seg_recip(seg));

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      x <= X_W'(current_lux) * X_W'(gain_coef);
    end
    if (cmd.seg) begin
      seg <= nbelow[SEG_W-1:0];
      sat <= !current_valid || (nbelow == (SEG_W + 1)'(NSEG));
      off <= {5'(x_hi - LUX_W'(x0)), x[15:0]};
    end
    if (cmd.prod) begin
      q <= slope_prod[PROD_W-1:16];
    end
    if (cmd.quot) begin
      lvl <= seg_y0(seg) + quot_prod[RECIP_SHIFT+LEVEL_W-1:RECIP_SHIFT];
    end
    if (cmd.load) begin
      level     <= sat ? LEVEL_W'(LEVEL_MAX) : lvl;
      lux_known <= current_valid;
      held_lux  <= current_valid ? current_lux : '0;
    end
  end

endmodule

// ----- dv/ambient_light_level_tracker_tb.sv -----
// Self-checking testbench for ambient_light_level_tracker: directed words, then random phases.
// Depends on allt_pkg and the tracker RTL; holds its own scoreboard class and drivers.
module ambient_light_level_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import allt_pkg::*;

  // Timeout: a slow correct word costs its block sequence, a few sender gaps and a
  // few receiver stalls. Around 925 words, one long receiver hold-off and the drains
  // fit well inside RUN_LIMIT, which leaves ample room.
  localparam int RUN_LIMIT       = 200000;
  localparam int WORDS_PER_PHASE = 150;
  localparam int NPHASE          = 6;
  localparam int SETTLE          = 8;
  localparam int STALL_LEN       = 300;
  localparam int IDLE_PCT        = 26;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               known;
    logic [LUX_W-1:0]   held;
  } light_result_t;

  // Tracks held lux, window and registers; queues one expected result per word.
  class light_board;
    logic [EXP_W-1:0]  exposure;
    logic [GAIN_W-1:0] gain;
    logic [LUX_W-1:0]  held;
    logic              known;
    logic [LUX_W-1:0]  peak;
    logic [TICK_W-1:0] win_start;
    light_result_t     awaited[$];
    int                errors;
    int unsigned       knee_lux[9];
    int unsigned       knee_lvl[9];

    function new();
      knee_lux  = '{0, 5, 10, 15, 20, 30, 50, 70, 100};
      knee_lvl  = '{0, 10, 24, 34, 50, 61, 77, 89, LEVEL_MAX};
      exposure  = EXP_RESET;
      gain      = GAIN_RESET;
      held      = '0;
      known     = 1'b0;
      peak      = '0;
      win_start = '0;
      errors    = 0;
    endfunction

    // lux * gain is in 2^-16 lux; knees are whole lux
    function logic [LEVEL_W-1:0] level_for(logic [LUX_W-1:0] l);
      longint unsigned x;
      longint unsigned xa;
      longint unsigned xb;
      longint unsigned dy;
      x = l;
      x = x * gain;
      for (int i = 0; i < 8; i++) begin
        xa = knee_lux[i] * 64'd65536;
        xb = knee_lux[i+1] * 64'd65536;
        if (x < xb) begin
          dy = knee_lvl[i+1] - knee_lvl[i];
          return LEVEL_W'(knee_lvl[i] + dy * (x - xa) / (xb - xa));
        end
      end
      return LEVEL_W'(LEVEL_MAX);
    endfunction

    function void close_window(logic [TICK_W-1:0] now);
      win_start = now;
      held      = peak;
      known     = 1'b1;
      peak      = '0;
    endfunction

    function void note_word(logic f, logic [LUX_W-1:0] l, logic [TICK_W-1:0] now);
      logic [TICK_W-1:0] age;
      light_result_t     r;
      age = now - win_start;
      if (f == OP_FAIL) begin
        known = 1'b0;
      end else if (!known || held < l) begin
        peak = l;
        close_window(now);
      end else begin
        if (peak < l) peak = l;
        if (age >= TICK_W'(exposure)) close_window(now);
      end
      r.level = known ? level_for(held) : LEVEL_W'(LEVEL_MAX);
      r.known = known;
      r.held  = known ? held : '0;
      awaited.push_back(r);
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    endfunction

    function void check_word(logic [LEVEL_W-1:0] lv, logic kn, logic [LUX_W-1:0] hl);
      light_result_t want;
      if (awaited.size() == 0) begin
        flag("unexpected word, level", 0, lv);
        return;
      end
      want = awaited.pop_front();
      if (lv !== want.level) flag("level", want.level, lv);
      if (kn !== want.known) flag("lux_known", want.known, kn);
      if (hl !== want.held) flag("held_lux", want.held, hl);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic               cfg_index = CFG_EXPOSURE;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               op = OP_SAMPLE;
  logic [LUX_W-1:0]   lux = '0;
  logic [TICK_W-1:0]  now_ms = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [LEVEL_W-1:0] level;
  logic               lux_known;
  logic [LUX_W-1:0]   held_lux;

  logic               calm = 1'b0;        // no idling on either side
  logic               want_stall = 1'b0;  // asks the receiver for its long hold-off
  logic [TICK_W-1:0]  tick_now = '0;

  light_board board = new();

  always #4 clk = ~clk;

  ambient_light_level_tracker u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .lux       (lux),
    .now_ms    (now_ms),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .level     (level),
    .lux_known (lux_known),
    .held_lux  (held_lux)
  );

  // Offer one word, with random idle cycles first; valid is left high on return so a
  // following word goes out back to back. Handshake is judged on pre-edge values.
  task automatic send_word(input logic f, input logic [LUX_W-1:0] l,
                           input logic [TICK_W-1:0] t);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= f;
    lux      <= l;
    now_ms   <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_word(f, l, t);
  endtask

  // Sender goes quiet until every result is back, then lets the pipe settle.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Only called with the block idle. Both registers are written every time.
  task automatic set_regs(input logic [EXP_W-1:0] e, input logic [GAIN_W-1:0] g);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_EXPOSURE;
    cfg_data  <= CFG_W'(e);
    @(posedge clk);
    board.exposure = e;
    cfg_index <= CFG_GAIN;
    cfg_data  <= CFG_W'(g);
    @(posedge clk);
    board.gain = g;
    cfg_we <= 1'b0;
  endtask

  // Random word, mostly shaped so levels land inside the knee table and windows
  // actually expire; the rest is full-range noise and tick jumps.
  task automatic random_word();
    int              r;
    logic            f;
    logic [LUX_W-1:0] l;
    longint unsigned span;
    r = $urandom_range(99);
    f = (r < 8) ? OP_FAIL : OP_SAMPLE;
    // one above the largest lux that maps at or below the top knee at this gain
    span = (board.gain == 0) ? 64'hFFFFF : (64'd100 * 65536) / board.gain + 1;
    if (span > 64'hFFFFF) span = 64'hFFFFF;
    r = $urandom_range(99);
    if (r < 40)      l = LUX_W'($urandom_range(int'(span)));
    else if (r < 60) l = board.held + LUX_W'($urandom_range(8)) - LUX_W'(4);
    else if (r < 72) l = board.held;
    else if (r < 90) l = LUX_W'($urandom);
    else             l = LUX_W'($urandom_range(16));
    r = $urandom_range(99);
    if (r < 50)      tick_now = tick_now + $urandom_range(600);
    else if (r < 75) tick_now = tick_now + $urandom_range(2 * board.exposure + 2);
    else if (r < 90) tick_now = board.win_start + board.exposure - $urandom_range(1);
    else             tick_now = $urandom;
    send_word(f, l, tick_now);
  endtask

  // Result side: checks on the pre-edge handshake, then picks next ready.
  initial begin : result_side
    int stall_left;
    bit stall_taken;
    stall_left  = 0;
    stall_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        board.check_word(level, lux_known, held_lux);
      if (want_stall && !stall_taken) begin
        stall_taken = 1'b1;
        stall_left  = STALL_LEN;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    logic [EXP_W-1:0]  e;
    logic [GAIN_W-1:0] g;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset registers (4000 ms, gain 1.0).
    send_word(OP_SAMPLE, 20'd0, 32'd0);        // unknown held value: taken at once
    send_word(OP_SAMPLE, 20'd0, 32'd10);       // equal sample only touches the peak
    send_word(OP_FAIL, 20'hFFFFF, 32'd20);     // failure, lux ignored, level max
    send_word(OP_SAMPLE, 20'd80, 32'd30);      // unknown again; exactly on the 5 lux knee
    // climb through the knees, each one brighter so it is taken at once
    send_word(OP_SAMPLE, 20'd159, 32'd40);
    send_word(OP_SAMPLE, 20'd160, 32'd50);
    send_word(OP_SAMPLE, 20'd239, 32'd60);
    send_word(OP_SAMPLE, 20'd320, 32'd70);
    send_word(OP_SAMPLE, 20'd480, 32'd80);
    send_word(OP_SAMPLE, 20'd799, 32'd90);
    send_word(OP_SAMPLE, 20'd1120, 32'd100);
    send_word(OP_SAMPLE, 20'd1599, 32'd110);
    send_word(OP_SAMPLE, 20'd1600, 32'd130);   // 100 lux: clamped
    send_word(OP_SAMPLE, 20'hFFFFF, 32'd140);  // largest lux, window opens at 140
    send_word(OP_SAMPLE, 20'd800, 32'd200);    // dimmer: peak only
    send_word(OP_SAMPLE, 20'd400, 32'd4139);   // one tick short of expiry
    send_word(OP_SAMPLE, 20'd100, 32'd4140);   // expiry: peak becomes held
    // tick wrap: window opens just below 2^32, ages across zero
    send_word(OP_SAMPLE, 20'd900, 32'hFFFF_FF00);
    send_word(OP_SAMPLE, 20'd0, 32'h0000_0E9F);
    send_word(OP_SAMPLE, 20'd0, 32'h0000_0EA0);
    send_word(OP_FAIL, 20'd0, 32'h0000_0F00);
    send_word(OP_SAMPLE, 20'd0, 32'h0000_0F10);  // dimmer, but held is unknown
    send_word(OP_SAMPLE, 20'hAAAAA, 32'h5555_5555);
    send_word(OP_SAMPLE, 20'h55555, 32'hAAAA_AAAA);
    wait_all_results();

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < NPHASE; phase++) begin
      case (phase)
        0: begin e = '0;              g = '1;              end  // zero exposure, max gain
        1: begin e = '1;              g = '0;              end  // longest window, no gain
        2: begin e = EXP_W'(300);     g = GAIN_RESET;      end
        3: begin e = EXP_W'($urandom); g = GAIN_W'($urandom); end
        4: begin e = EXP_W'(1);       g = GAIN_W'(1);      end
        default: begin
          e = EXP_W'($urandom_range(5000));
          g = GAIN_W'($urandom_range(16384, 2048));
        end
      endcase
      set_regs(e, g);
      if (phase == 3) calm <= 1'b1;
      if (phase == 4) tick_now = 32'hFFFF_F000;  // ticks wrap early in this phase
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // receiver holds off for a long stretch while words keep coming
        if (phase == 2 && n == 20) want_stall <= 1'b1;
        // sender pauses until everything is back
        if (phase == 1 && n == 75) wait_all_results();
        random_word();
      end
      wait_all_results();
      if (phase == 3) calm <= 1'b0;
    end

    if (board.errors == 0 && board.awaited.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- ambient_light_level_tracker.f -----
src/allt_pkg.sv
src/allt_ctrl.sv
src/allt_dp.sv
src/ambient_light_level_tracker.sv
dv/ambient_light_level_tracker_tb.sv
